@@ design/base85_stream_codec_macros.svh @@
// assertion macros for the base85 stream codec
`ifndef BASE85_STREAM_CODEC_MACROS_SVH
`define BASE85_STREAM_CODEC_MACROS_SVH

// same-cycle implication under synchronous reset
`define B85_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under synchronous reset
`define B85_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/b85sc_pkg.sv @@
// shared constants, tables and types of the base85 stream codec
`default_nettype none

package b85sc_pkg;

  localparam int unsigned Radix = 85;

  // character set, first digit in the top byte of the vector
  localparam logic [Radix*8-1:0] ALPHABET =
    " !#$'()+,-0123456789:;<=>@ABCDEFGHIJKLMNOPQRSTUVWXYZ[]^_abcdefghijklmnopqrstuvwxyz{}~";

  // ceil(2^38 / 85): quotient of a 32-bit word by 85 is (v * RECIP) >> 38
  localparam logic [31:0] RECIP = 32'hC0C0_C0C1;
  localparam int unsigned RecipShift = 38;

  // marker for a character outside the set
  localparam logic [6:0] DIGIT_BAD = 7'(Radix);

  // control of the shared arithmetic unit
  typedef struct packed {
    logic load;  // capture a new product
    logic dec;   // digit times power of 85, else word times reciprocal
  } alu_ctl_t;

  // digit value to character code
  function automatic logic [7:0] enc_char(input logic [6:0] d);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < Radix; i++) begin
      if (d == 7'(i)) begin
        c = ALPHABET[(Radix-1-i)*8 +: 8];
      end
    end
    return c;
  endfunction

  // character code to digit value, DIGIT_BAD if not in the set
  function automatic logic [6:0] char_digit(input logic [7:0] c);
    logic [6:0] d;
    d = DIGIT_BAD;
    for (int i = 0; i < Radix; i++) begin
      if (ALPHABET[(Radix-1-i)*8 +: 8] == c) begin
        d = 7'(i);
      end
    end
    return d;
  endfunction

  // weight of a digit by its place in the group
  function automatic logic [31:0] pow85(input logic [2:0] idx);
    logic [31:0] p;
    case (idx)
      3'd0: p = 32'd1;
      3'd1: p = 32'd85;
      3'd2: p = 32'd7225;
      3'd3: p = 32'd614125;
      3'd4: p = 32'd52200625;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ design/b85sc_alu.sv @@
// shared multiplier with registered product, plus the remainder and accumulate adders
`default_nettype none

module b85sc_alu
  import b85sc_pkg::*;
(
  input  wire logic        clk,
  input  wire alu_ctl_t    ctl,
  input  wire logic [31:0] word,
  input  wire logic [6:0]  digit,
  input  wire logic [2:0]  place,
  output logic      [25:0] quot,
  output logic      [6:0]  rem,
  output logic      [31:0] sum
);

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [31:0] back;

  // operand select
  always_comb begin
    if (ctl.dec) begin
      op_a = {25'd0, digit};
      op_b = pow85(place);
    end else begin
      op_a = word;
      op_b = RECIP;
    end
  end

  // one 32x32 multiply, registered
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= op_a * op_b;
    end
  end

  // quotient by 85, the digit left over and the accumulated sum
  always_comb begin
    quot = prod[RecipShift +: 26];
    back = {6'd0, quot} * 32'd85;
    rem  = 7'(word - back);
    sum  = word + prod[31:0];
  end

endmodule

`default_nettype wire

@@ design/base85_stream_codec.sv @@
// encode: each byte taken in passes S_IDLE and S_LOAD; a closing group then passes S_MUL and S_DIG
//   for each character (multiply by reciprocal, split off digit), so 4 bytes give 5 characters
// decode: each character passes take, look up, multiply by place weight and accumulate,
//   then S_BYTES sends the bytes out, low byte first
// output stalls hold the sequencer; rst clears state, discard, group and tvalid, direction = encode
`default_nettype none

module base85_stream_codec
  import b85sc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration: direction, 0 encode, 1 decode
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  // input words
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  // result words
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // out_last
  output logic            m_axis_tuser    // [0] bad_input
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIG   = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_BYTES = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic        direction, direction_next;
  logic        discarding, discarding_next;
  logic [31:0] group_word, group_word_next;
  logic [2:0]  group_count, group_count_next;
  logic [6:0]  digit, digit_next;
  logic [7:0]  in_b, in_b_next;
  logic        in_l, in_l_next;
  logic [2:0]  emit_n, emit_n_next;
  logic [2:0]  emit_k, emit_k_next;
  logic        out_v_next;
  logic [7:0]  out_d_next;
  logic        out_l_next;
  logic        out_e_next;

  logic        s_accept;
  logic        cfg_accept;
  logic        out_free;
  logic [2:0]  cnt_inc;
  logic [6:0]  lut_digit;
  logic [31:0] gather;
  alu_ctl_t    alu_ctl;
  logic [25:0] quot;
  logic [6:0]  rem;
  logic [31:0] sum;

  // a direction write takes the idle slot ahead of an input word
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_accept    = cfg_valid && cfg_ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign lut_digit = char_digit(in_b);
  assign gather    = group_word | ({24'd0, in_b} << {group_count[1:0], 3'b000});
  assign cnt_inc   = {1'b0, group_count[1:0]} + 3'd1;

  assign alu_ctl.load = (state == S_MUL);
  assign alu_ctl.dec  = direction;

  b85sc_alu u_alu (
    .clk   (clk),
    .ctl   (alu_ctl),
    .word  (group_word),
    .digit (digit),
    .place (group_count),
    .quot  (quot),
    .rem   (rem),
    .sum   (sum)
  );

  // sequencer
  always_comb begin
    state_next       = state;
    direction_next   = direction;
    discarding_next  = discarding;
    group_word_next  = group_word;
    group_count_next = group_count;
    digit_next       = digit;
    in_b_next        = in_b;
    in_l_next        = in_l;
    emit_n_next      = emit_n;
    emit_k_next      = emit_k;
    out_v_next       = m_axis_tvalid && !m_axis_tready;
    out_d_next       = m_axis_tdata;
    out_l_next       = m_axis_tlast;
    out_e_next       = m_axis_tuser;

    case (state)
      S_IDLE: begin
        if (cfg_accept) begin
          direction_next   = cfg_data;
          discarding_next  = 1'b0;
          group_word_next  = '0;
          group_count_next = '0;
        end else if (s_accept) begin
          in_b_next  = s_axis_tdata;
          in_l_next  = s_axis_tlast;
          state_next = S_LOAD;
        end
      end

      S_LOAD: begin
        if (discarding) begin
          // swallow up to the end of the stream
          if (in_l) begin
            discarding_next  = 1'b0;
            group_word_next  = '0;
            group_count_next = '0;
          end
          state_next = S_IDLE;
        end else if (!direction) begin
          // encode: gather a byte, start digits on a full or closing group
          group_word_next = gather;
          emit_k_next     = '0;
          if (cnt_inc == 3'd4) begin
            emit_n_next      = 3'd5;
            group_count_next = '0;
            state_next       = S_MUL;
          end else if (in_l) begin
            emit_n_next      = cnt_inc + 3'd1;
            group_count_next = '0;
            state_next       = S_MUL;
          end else begin
            group_count_next = cnt_inc;
            state_next       = S_IDLE;
          end
        end else begin
          // decode: look the character up
          digit_next = lut_digit;
          if (lut_digit == DIGIT_BAD) begin
            state_next = S_ERR;
          end else begin
            state_next = S_MUL;
          end
        end
      end

      S_MUL: begin
        state_next = direction ? S_ACC : S_DIG;
      end

      S_DIG: begin
        // one digit per pass, least significant first
        if (out_free) begin
          out_v_next      = 1'b1;
          out_d_next      = enc_char(rem);
          out_l_next      = in_l && (emit_k == emit_n - 3'd1);
          out_e_next      = 1'b0;
          group_word_next = {6'd0, quot};
          emit_k_next     = emit_k + 3'd1;
          if (emit_k == emit_n - 3'd1) begin
            group_word_next = '0;
            state_next      = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end

      S_ACC: begin
        group_word_next = sum;
        emit_k_next     = '0;
        if (group_count == 3'd4) begin
          emit_n_next = 3'd4;
          state_next  = S_BYTES;
        end else if (in_l) begin
          if (group_count == 3'd0) begin
            state_next = S_ERR;
          end else begin
            emit_n_next = group_count;
            state_next  = S_BYTES;
          end
        end else begin
          group_count_next = group_count + 3'd1;
          state_next       = S_IDLE;
        end
      end

      S_BYTES: begin
        // low byte first
        if (out_free) begin
          out_v_next      = 1'b1;
          out_d_next      = group_word[7:0];
          out_l_next      = in_l && (emit_k == emit_n - 3'd1);
          out_e_next      = 1'b0;
          group_word_next = {8'd0, group_word[31:8]};
          emit_k_next     = emit_k + 3'd1;
          if (emit_k == emit_n - 3'd1) begin
            group_word_next  = '0;
            group_count_next = '0;
            state_next       = S_IDLE;
          end
        end
      end

      S_ERR: begin
        // single error word, then drop the rest of the stream
        if (out_free) begin
          out_v_next       = 1'b1;
          out_d_next       = 8'h00;
          out_l_next       = 1'b1;
          out_e_next       = 1'b1;
          group_word_next  = '0;
          group_count_next = '0;
          discarding_next  = !in_l;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      direction     <= 1'b0;
      discarding    <= 1'b0;
      group_word    <= '0;
      group_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      direction     <= direction_next;
      discarding    <= discarding_next;
      group_word    <= group_word_next;
      group_count   <= group_count_next;
      m_axis_tvalid <= out_v_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    digit        <= digit_next;
    in_b         <= in_b_next;
    in_l         <= in_l_next;
    emit_n       <= emit_n_next;
    emit_k       <= emit_k_next;
    m_axis_tdata <= out_d_next;
    m_axis_tlast <= out_l_next;
    m_axis_tuser <= out_e_next;
  end

  `include "base85_stream_codec_macros.svh"

  `B85_ASSERT_IMP(a_err_word, clk, rst, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata == 8'h00 && m_axis_tlast, "error word must be zero and last")
  `B85_ASSERT_NXT(a_busy_after_take, clk, rst, s_accept,
    !s_axis_tready && state == S_LOAD, "sequencer must go busy after taking a word")
  `B85_ASSERT_NXT(a_cfg_clears, clk, rst, cfg_accept,
    group_count == 3'd0 && !discarding && group_word == 32'd0,
    "direction write must clear the group")

endmodule

`default_nettype wire

@@ verif/base85_tb_pkg.sv @@
// shared types of the base85 stream codec testbench
`timescale 1ns / 100ps

package base85_tb_pkg;

  // direction register values
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } codec_dir_e;

endpackage

@@ verif/base85_checker.sv @@
// monitor, predictor and scoreboard of the base85 stream codec
`timescale 1ns / 100ps

module base85_checker
  import base85_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic        [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // in_last
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic        [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic              m_axis_tlast,   // out_last
  input  logic              m_axis_tuser,   // [0] bad_input
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       words_in,
  output int unsigned       words_out,
  output int unsigned       bad_words
);

  // digit set, digit 0 in the top byte
  localparam logic [85*8-1:0] DigitChars =
    " !#$'()+,-0123456789:;<=>@ABCDEFGHIJKLMNOPQRSTUVWXYZ[]^_abcdefghijklmnopqrstuvwxyz{}~";
  localparam logic [6:0] NoDigit = 7'd85;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } result_word_t;

  result_word_t expected_q[$];
  logic [6:0]   digit_lut[256];

  // predicted codec state
  codec_dir_e  dir_now;
  logic [31:0] acc_word;
  logic [2:0]  acc_count;
  logic        skipping;

  int unsigned fails;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_bad;

  function automatic logic [7:0] digit_char(input logic [6:0] d);
    return DigitChars[(84 - int'(d))*8 +: 8];
  endfunction

  function automatic logic [31:0] place_weight(input logic [2:0] k);
    logic [31:0] w;
    w = 32'd1;
    for (int i = 0; i < int'(k); i++) begin
      w = w * 32'd85;
    end
    return w;
  endfunction

  // inverse lookup, everything outside the set maps to no digit
  initial begin
    for (int i = 0; i < 256; i++) begin
      digit_lut[i] = NoDigit;
    end
    for (int d = 0; d < 85; d++) begin
      digit_lut[digit_char(7'(d))] = 7'(d);
    end
  end

  task automatic push_result(input logic [7:0] data, input logic last, input logic bad);
    expected_q.push_back('{data: data, last: last, bad: bad});
  endtask

  // digits of v, least significant first
  task automatic queue_chars(input logic [31:0] v, input int n, input logic last);
    logic [31:0] rest;
    rest = v;
    for (int k = 0; k < n; k++) begin
      push_result(digit_char(7'(rest % 32'd85)), last && (k == n - 1), 1'b0);
      rest = rest / 32'd85;
    end
  endtask

  // bytes of v, low byte first
  task automatic queue_bytes(input logic [31:0] v, input int n, input logic last);
    for (int k = 0; k < n; k++) begin
      push_result(v[8*k +: 8], last && (k == n - 1), 1'b0);
    end
  endtask

  task automatic clear_group();
    acc_word  = 32'd0;
    acc_count = 3'd0;
  endtask

  // expected results of one accepted input word
  task automatic predict_word(input logic [7:0] b, input logic last);
    logic [6:0] d;
    int         c;
    if (skipping) begin
      // swallowed until the end of the stream
      if (last) begin
        skipping = 1'b0;
        clear_group();
      end
    end else if (dir_now == DIR_ENCODE) begin
      acc_word = acc_word | ({24'd0, b} << (8 * int'(acc_count[1:0])));
      c = int'(acc_count[1:0]) + 1;
      if (c == 4) begin
        queue_chars(acc_word, 5, last);
      end else if (last) begin
        queue_chars(acc_word, c + 1, 1'b1);
      end
      if (c == 4 || last) begin
        clear_group();
      end else begin
        acc_count = 3'(c);
      end
    end else begin
      d = digit_lut[b];
      if (d == NoDigit) begin
        // illegal character ends the stream with an error word
        push_result(8'd0, 1'b1, 1'b1);
        clear_group();
        skipping = !last;
      end else begin
        acc_word = acc_word + {25'd0, d} * place_weight(acc_count);
        c = int'(acc_count) + 1;
        if (c == 5) begin
          queue_bytes(acc_word, 4, last);
        end else if (last) begin
          if (c == 1) begin
            // lone final character
            push_result(8'd0, 1'b1, 1'b1);
          end else begin
            queue_bytes(acc_word, c - 1, 1'b1);
          end
        end
        if (c == 5 || last) begin
          clear_group();
        end else begin
          acc_count = 3'(c);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // watch the three channels
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst) begin
      dir_now  = DIR_ENCODE;
      skipping = 1'b0;
      clear_group();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        dir_now  = codec_dir_e'(cfg_data);
        skipping = 1'b0;
        clear_group();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_in++;
        predict_word(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (m_axis_tuser === 1'b1) begin
          n_bad++;
        end
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, got data %h last %b bad %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          exp_word = expected_q.pop_front();
          if (m_axis_tdata !== exp_word.data) begin
            note_mismatch("out_byte", exp_word.data, m_axis_tdata);
          end
          if (m_axis_tlast !== exp_word.last) begin
            note_mismatch("out_last", {7'd0, exp_word.last}, {7'd0, m_axis_tlast});
          end
          if (m_axis_tuser !== exp_word.bad) begin
            note_mismatch("bad_input", {7'd0, exp_word.bad}, {7'd0, m_axis_tuser});
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_q.size();
    words_in   <= n_in;
    words_out  <= n_out;
    bad_words  <= n_bad;
  end

endmodule

@@ verif/base85_stream_codec_tb.sv @@
// stimulus, flow control and verdict for the base85 stream codec
`timescale 1ns / 100ps

module base85_stream_codec_tb
  import b85sc_pkg::*, base85_tb_pkg::*;
;

  localparam int ResetCycles  = 10;
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 40;
  localparam int LongHold     = 300;
  // printable characters left out of the digit set
  localparam logic [79:0] OffSetChars = "\"%&*./?\\`|";

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;   // out_last
  logic       m_axis_tuser;   // [0] bad_input

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned bad_words;

  codec_dir_e  dir_now;
  int          burst_left;
  logic        hold_req;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  base85_stream_codec u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  base85_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_in      (words_in),
    .words_out     (words_out),
    .bad_words     (bad_words)
  );

  // one input word, sent in bursts with random gaps between them
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_fill(input logic [7:0] b, input int n, input logic close);
    for (int i = 0; i < n; i++) begin
      send_word(b, close && (i == n - 1));
    end
  endtask

  // character code outside the digit set
  function automatic logic [7:0] off_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 2);
    case (r)
      0: begin
        c = {1'b1, 7'($urandom)};
      end
      1: begin
        r = $urandom_range(0, 32);
        c = (r == 32) ? 8'h7f : 8'(r);
      end
      default: begin
        r = $urandom_range(0, 9);
        c = OffSetChars[(9 - r)*8 +: 8];
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] digit_code();
    return ALPHABET[(Radix - 1 - $urandom_range(0, Radix - 1))*8 +: 8];
  endfunction

  // one stream closed by tlast, content by direction
  task automatic send_stream(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (dir_now == DIR_ENCODE) begin
        b = 8'($urandom);
      end else if ($urandom_range(0, 39) == 0) begin
        b = off_char();
      end else begin
        b = digit_code();
      end
      send_word(b, i == len - 1);
    end
  endtask

  task automatic random_streams(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if (dir_now == DIR_ENCODE) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 16);
      end else begin
        len = 5 * $urandom_range(0, 3) + $urandom_range(0, 4);
      end
      if (len < 1) begin
        len = 1;
      end
      if (len > budget - sent) begin
        len = budget - sent;
      end
      send_stream(len);
      sent += len;
    end
  endtask

  // stop sending until every expected word is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_direction(input codec_dir_e d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dir_now = d;
  endtask

  // receiver flow control, with a long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run limit of %0d cycles reached, %0d words outstanding",
               $time, CycleLimit, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    hold_req      = 1'b0;
    burst_left    = 0;
    dir_now       = DIR_ENCODE;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // encode: zero and all-ones groups, then tails of one, two and three bytes
    set_direction(DIR_ENCODE);
    send_fill(8'h00, 4, 1'b0);
    send_fill(8'hff, 4, 1'b1);
    send_word(8'h80, 1'b1);
    send_word(8'h01, 1'b0);
    send_word(8'hfe, 1'b1);
    send_word(8'h7f, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'haa, 1'b1);
    drain();

    // decode: top digits wrap past 32 bits, zero group, short tails
    set_direction(DIR_DECODE);
    send_fill("~", 5, 1'b1);
    send_fill(" ", 5, 1'b0);
    send_fill("0", 2, 1'b1);
    send_fill("z", 3, 1'b1);
    send_fill("}", 4, 1'b1);
    // lone final character
    send_word("!", 1'b1);
    // illegal character mid-stream, rest of the stream is dropped
    send_word(8'h80, 1'b0);
    send_word("A", 1'b0);
    send_word(8'hff, 1'b1);
    // illegal characters closing a stream
    send_word("\"", 1'b1);
    send_word(8'h00, 1'b1);
    drain();

    // random encode streams under a long output hold-off
    set_direction(DIR_ENCODE);
    hold_req = 1'b1;
    random_streams(35);
    drain();

    // random decode streams, again with a long hold-off
    set_direction(DIR_DECODE);
    hold_req = 1'b1;
    random_streams(35);
    drain();

    // encode, then leave a partial group for the direction write to clear
    set_direction(DIR_ENCODE);
    random_streams(30);
    send_word(8'($urandom), 1'b0);
    send_word(8'($urandom), 1'b0);
    drain();

    set_direction(DIR_DECODE);
    random_streams(30);
    drain();

    if (pending != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, pending);
    end
    $display("covered %0d input words and %0d result words (%0d error words) in both directions",
             words_in, words_out, bad_words);
    $display("incl. partial groups, lone and illegal characters, dropped streams, long stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ base85_stream_codec.f @@
+incdir+design
design/b85sc_pkg.sv
design/b85sc_alu.sv
design/base85_stream_codec.sv
verif/base85_tb_pkg.sv
verif/base85_checker.sv
verif/base85_stream_codec_tb.sv
